// ===== rtl/cha_pkg.sv =====
package cha_pkg;

  localparam int MAX_HITS = 64;
  localparam int CNT_W    = 7;
  localparam int ID_W     = 12;
  localparam int E_W      = 24;
  localparam int SUM_W    = 32;
  localparam int SIDE_W   = 7;
  localparam int LEN_W    = 16;
  localparam int POS_W    = 13;
  localparam int Z_W      = 15;
  localparam int DIV_W    = 26;
  localparam int DVS_W    = 8;
  localparam int CIDX_W   = 2;

  localparam logic [CIDX_W-1:0] REG_SIDE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LEN  = 2'd1;

  localparam logic [SIDE_W-1:0] SIDE_RST = 7'd8;
  localparam logic [LEN_W-1:0]  LEN_RST  = 16'd3200;

  localparam logic signed [14:0] PITCH = 15'sd2400;

  typedef struct packed {
    logic cmp;
    logic upd;
    logic any;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/cha_cell.sv =====
module cha_cell (
  input  logic                       clk,
  input  cha_pkg::cell_ctrl_t        ctrl,
  input  logic                       occ,
  input  logic                       app_sel,
  input  logic [cha_pkg::ID_W-1:0]   cmp_id,
  input  logic [cha_pkg::ID_W-1:0]   wr_id,
  input  logic [cha_pkg::E_W-1:0]    wr_e,
  input  logic [cha_pkg::ID_W-1:0]   nbr_id,
  input  logic [cha_pkg::SUM_W-1:0]  nbr_sum,
  output logic [cha_pkg::ID_W-1:0]   id,
  output logic [cha_pkg::SUM_W-1:0]  sum,
  output logic                       match
);

  logic [cha_pkg::SUM_W:0] acc;

  assign acc = {1'b0, sum} + (cha_pkg::SUM_W+1)'(wr_e);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match <= occ && (id == cmp_id);
    end
    if (ctrl.shift) begin
      id  <= nbr_id;
      sum <= nbr_sum;
    end else if (ctrl.upd) begin
      if (match) begin
        sum <= acc[cha_pkg::SUM_W] ? '1 : acc[cha_pkg::SUM_W-1:0];
      end else if (!ctrl.any && app_sel) begin
        id  <= wr_id;
        sum <= cha_pkg::SUM_W'(wr_e);
      end
    end
  end

endmodule

// ===== rtl/cha_div.sv =====
module cha_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cha_pkg::DIV_W-1:0]  dividend,
  input  logic [cha_pkg::DVS_W-1:0]  divisor,
  output logic [cha_pkg::DIV_W-1:0]  quot,
  output logic [cha_pkg::DVS_W-1:0]  rem,
  output logic                       done
);

  logic                       busy;
  logic [4:0]                 cnt;
  logic [cha_pkg::DVS_W-1:0]  dvs;
  logic [cha_pkg::DVS_W:0]    trial;
  logic                       fit;

  assign trial = {rem, quot[cha_pkg::DIV_W-1]};
  assign fit   = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(cha_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[cha_pkg::DIV_W-2:0], fit};
      rem  <= fit ? cha_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[cha_pkg::DVS_W-1:0];
    end
  end

endmodule

// ===== rtl/crystal_hit_accumulator.sv =====
// Crystal hit list accumulator.
// Input channel (in_valid/in_ready): req_type 0 is a deposit of deposit_energy
// on crystal_id, req_type 1 ends the event. A deposit first compares the id
// against every listed cell, then adds or appends.
// An end of event flushes the list in order of first hit, one output beat per
// entry (a single beat with entry_valid 0 when the list is empty), last set on
// the final beat, then clears the list and the overflow flag. Each entry is
// worked out with the bit-serial dividers: after a setup step, the row and
// column split of the id, then a multiply, then the centre coordinates, then
// the emit.
// Input is not accepted again until a flush finishes.
// Output channel (out_valid/out_ready) is a single register; when the receiver
// stalls the block holds the beat and waits before shifting the list.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 array side, index 1 crystal length; write only while idle.
// Reset (rst, synchronous) empties the list, clears overflow, and restores
// side 8 and length 3200.
module crystal_hit_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [cha_pkg::ID_W-1:0]          crystal_id,
  input  logic [cha_pkg::E_W-1:0]           deposit_energy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              entry_valid,
  output logic [cha_pkg::ID_W-1:0]          hit_crystal,
  output logic [cha_pkg::SUM_W-1:0]         energy_sum,
  output logic signed [cha_pkg::POS_W-1:0]  pos_x,
  output logic signed [cha_pkg::POS_W-1:0]  pos_y,
  output logic [cha_pkg::Z_W-1:0]           pos_z,
  output logic                              overflow,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cha_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [cha_pkg::LEN_W-1:0]         cfg_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MATCH   = 3'd1;
  localparam logic [2:0] S_ID_GO   = 3'd2;
  localparam logic [2:0] S_ID_WAIT = 3'd3;
  localparam logic [2:0] S_MUL     = 3'd4;
  localparam logic [2:0] S_XY_GO   = 3'd5;
  localparam logic [2:0] S_XY_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0]                  state;
  logic [cha_pkg::SIDE_W-1:0]  side;
  logic [cha_pkg::LEN_W-1:0]   clen;
  logic [cha_pkg::CNT_W-1:0]   count;
  logic [cha_pkg::CNT_W-1:0]   left;
  logic                        dropped;
  logic                        emp;
  logic [cha_pkg::ID_W-1:0]    wr_id;
  logic [cha_pkg::E_W-1:0]     wr_e;

  logic [cha_pkg::ID_W-1:0]    ids  [cha_pkg::MAX_HITS];
  logic [cha_pkg::SUM_W-1:0]   sums [cha_pkg::MAX_HITS];
  logic [cha_pkg::MAX_HITS-1:0] hit_flags;
  cha_pkg::cell_ctrl_t         ctrl;

  logic [cha_pkg::SIDE_W-1:0]  n;
  logic                        accept;
  logic                        slot;
  logic                        any;

  logic                        dx_start, dy_start;
  logic [cha_pkg::DIV_W-1:0]   dx_dend, dy_dend;
  logic [cha_pkg::DVS_W-1:0]   dx_dvs, dy_dvs;
  logic [cha_pkg::DIV_W-1:0]   qx, qy;
  logic [cha_pkg::DVS_W-1:0]   rx, ry;
  logic                        dx_done, dy_done;

  logic signed [14:0]          tx, ty;
  logic signed [27:0]          px, py;
  logic [27:0]                 mx, my;
  logic signed [cha_pkg::POS_W-1:0] cx, cy;
  logic [16:0]                 zh;
  logic [cha_pkg::Z_W-1:0]     zs;

  assign n         = (side == '0) ? cha_pkg::SIDE_W'(1) : side;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign slot      = !out_valid || out_ready;
  assign any       = |hit_flags;

  assign ctrl.cmp   = accept && !req_type;
  assign ctrl.upd   = (state == S_MATCH);
  assign ctrl.any   = any;
  assign ctrl.shift = (state == S_EMIT) && slot && !emp;

  for (genvar k = 0; k < cha_pkg::MAX_HITS; k++) begin : g_cell
    logic [cha_pkg::ID_W-1:0]  nid;
    logic [cha_pkg::SUM_W-1:0] nsum;
    if (k == cha_pkg::MAX_HITS - 1) begin : g_end
      assign nid  = '0;
      assign nsum = '0;
    end else begin : g_mid
      assign nid  = ids[k+1];
      assign nsum = sums[k+1];
    end
    cha_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .occ     (cha_pkg::CNT_W'(k) < count),
      .app_sel (cha_pkg::CNT_W'(k) == count),
      .cmp_id  (crystal_id),
      .wr_id   (wr_id),
      .wr_e    (wr_e),
      .nbr_id  (nid),
      .nbr_sum (nsum),
      .id      (ids[k]),
      .sum     (sums[k]),
      .match   (hit_flags[k])
    );
  end

  // column/row split of the head id, then the x coordinate, share one divider
  assign dx_start = (state == S_ID_GO) || (state == S_XY_GO);
  assign dy_start = (state == S_XY_GO);
  assign dx_dend  = (state == S_ID_GO) ? cha_pkg::DIV_W'(ids[0])
                                       : cha_pkg::DIV_W'({mx[24:0], 1'b0}) +
                                         cha_pkg::DIV_W'(n);
  assign dx_dvs   = (state == S_ID_GO) ? {1'b0, n} : {n, 1'b0};
  assign dy_dend  = cha_pkg::DIV_W'({my[24:0], 1'b0}) + cha_pkg::DIV_W'(n);
  assign dy_dvs   = {n, 1'b0};

  cha_div u_divx (
    .clk (clk), .rst (rst), .start (dx_start), .dividend (dx_dend),
    .divisor (dx_dvs), .quot (qx), .rem (rx), .done (dx_done)
  );

  cha_div u_divy (
    .clk (clk), .rst (rst), .start (dy_start), .dividend (dy_dend),
    .divisor (dy_dvs), .quot (qy), .rem (ry), .done (dy_done)
  );

  assign tx = $signed({7'b0, rx[6:0], 1'b0}) - $signed({8'b0, n}) + 15'sd1;
  assign ty = $signed({2'b0, qx[11:0], 1'b0}) - $signed({8'b0, n}) + 15'sd1;
  assign mx = px[27] ? 28'(-px) : 28'(px);
  assign my = py[27] ? 28'(-py) : 28'(py);

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      px <= 28'(tx * cha_pkg::PITCH);
      py <= 28'(ty * cha_pkg::PITCH);
    end
  end

  // round-to-nearest magnitude back to signed, saturated to 13 bits
  always_comb begin
    if (!px[27]) begin
      cx = (qx > 26'd4095) ? 13'sd4095 : $signed(qx[12:0]);
    end else begin
      cx = (qx > 26'd4096) ? $signed(13'h1000) : $signed(13'(~qx[12:0] + 13'd1));
    end
    if (!py[27]) begin
      cy = (qy > 26'd4095) ? 13'sd4095 : $signed(qy[12:0]);
    end else begin
      cy = (qy > 26'd4096) ? $signed(13'h1000) : $signed(13'(~qy[12:0] + 13'd1));
    end
  end

  assign zh = ({1'b0, clen} + 17'd1) >> 1;
  assign zs = zh[16] ? '1 : zh[14:0] | {15{zh[15]}};

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_id <= crystal_id;
      wr_e  <= deposit_energy;
    end
    if (state == S_EMIT && slot) begin
      entry_valid <= !emp;
      hit_crystal <= emp ? '0 : ids[0];
      energy_sum  <= emp ? '0 : sums[0];
      pos_x       <= emp ? '0 : cx;
      pos_y       <= emp ? '0 : cy;
      pos_z       <= emp ? '0 : zs;
      overflow    <= dropped;
      last        <= emp || (left == cha_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side      <= cha_pkg::SIDE_RST;
      clen      <= cha_pkg::LEN_RST;
      count     <= '0;
      left      <= '0;
      dropped   <= 1'b0;
      emp       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cha_pkg::REG_SIDE) begin
          side <= cfg_data[cha_pkg::SIDE_W-1:0];
        end else if (cfg_index == cha_pkg::REG_LEN) begin
          clen <= cfg_data;
        end
      end
      if (state == S_EMIT && slot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!req_type) begin
              state <= S_MATCH;
            end else begin
              left  <= count;
              emp   <= (count == '0);
              state <= (count == '0) ? S_EMIT : S_ID_GO;
            end
          end
        end
        S_MATCH: begin
          if (!any) begin
            if (count < cha_pkg::CNT_W'(cha_pkg::MAX_HITS)) begin
              count <= count + cha_pkg::CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_ID_GO: state <= S_ID_WAIT;
        S_ID_WAIT: begin
          if (dx_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_XY_GO;
        S_XY_GO: state <= S_XY_WAIT;
        S_XY_WAIT: begin
          if (dx_done && dy_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot) begin
            left <= left - cha_pkg::CNT_W'(1);
            if (emp || left == cha_pkg::CNT_W'(1)) begin
              count   <= '0;
              dropped <= 1'b0;
              emp     <= 1'b0;
              state   <= S_IDLE;
            end else begin
              state <= S_ID_GO;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/crystal_hit_accumulator_test.sv =====
module crystal_hit_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [cha_pkg::ID_W-1:0] crystal_id = '0;
  logic [cha_pkg::E_W-1:0] deposit_energy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic entry_valid;
  logic [cha_pkg::ID_W-1:0] hit_crystal;
  logic [cha_pkg::SUM_W-1:0] energy_sum;
  logic signed [cha_pkg::POS_W-1:0] pos_x;
  logic signed [cha_pkg::POS_W-1:0] pos_y;
  logic [cha_pkg::Z_W-1:0] pos_z;
  logic overflow;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cha_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [cha_pkg::LEN_W-1:0] cfg_data = '0;

  localparam logic REQ_DEPOSIT = 1'b0;
  localparam logic REQ_FLUSH   = 1'b1;

  typedef struct packed {
    logic valid;
    logic [cha_pkg::ID_W-1:0] id;
    logic [cha_pkg::SUM_W-1:0] sum;
    logic signed [cha_pkg::POS_W-1:0] x;
    logic signed [cha_pkg::POS_W-1:0] y;
    logic [cha_pkg::Z_W-1:0] z;
    logic ovf;
    logic last;
  } hit_beat_t;

  crystal_hit_accumulator u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the hit list
  logic [cha_pkg::ID_W-1:0] list_ids[cha_pkg::MAX_HITS];
  logic [cha_pkg::SUM_W-1:0] list_sums[cha_pkg::MAX_HITS];
  int unsigned list_count;
  logic list_dropped;
  logic [cha_pkg::SIDE_W-1:0] side_reg = cha_pkg::SIDE_RST;
  logic [cha_pkg::LEN_W-1:0] len_reg = cha_pkg::LEN_RST;

  hit_beat_t pending_hits[$];
  int errors;
  int flushes;
  int beats_seen;
  bit calm;

  function automatic void stash_expected(hit_beat_t b);
    pending_hits = {pending_hits, b};
  endfunction

  function automatic logic signed [cha_pkg::POS_W-1:0] centre(longint i, longint n);
    longint num, mag, q, v;
    num = 2400 * (2 * i - n + 1);
    mag = num < 0 ? -num : num;
    q = (2 * mag + n) / (2 * n);
    v = num < 0 ? -q : q;
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return v[cha_pkg::POS_W-1:0];
  endfunction

  function automatic void predict(logic req, logic [cha_pkg::ID_W-1:0] id,
                                  logic [cha_pkg::E_W-1:0] e);
    longint s;
    longint n;
    longint z;
    hit_beat_t b;
    if (req == REQ_DEPOSIT) begin
      for (int k = 0; k < list_count; k++) begin
        if (list_ids[k] == id) begin
          s = longint'(list_sums[k]) + e;
          list_sums[k] = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
          return;
        end
      end
      if (list_count < cha_pkg::MAX_HITS) begin
        list_ids[list_count] = id;
        list_sums[list_count] = {8'd0, e};
        list_count++;
      end else begin
        list_dropped = 1'b1;
      end
      return;
    end
    n = side_reg == 0 ? 1 : side_reg;
    z = (longint'(len_reg) + 1) / 2;
    if (z > 32767) z = 32767;
    flushes++;
    if (list_count == 0) begin
      b = '0;
      b.ovf = list_dropped;
      b.last = 1'b1;
      stash_expected(b);
    end else begin
      for (int k = 0; k < list_count; k++) begin
        b.valid = 1'b1;
        b.id = list_ids[k];
        b.sum = list_sums[k];
        b.x = centre(list_ids[k] % n, n);
        b.y = centre(list_ids[k] / n, n);
        b.z = z[cha_pkg::Z_W-1:0];
        b.ovf = list_dropped;
        b.last = (k + 1 == list_count);
        stash_expected(b);
      end
    end
    list_count = 0;
    list_dropped = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (calm || pick_gap() == 0) out_ready = 1'b1;
    else out_ready = 1'b0;
  end

  always @(posedge clk) begin
    hit_beat_t exp_b;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (pending_hits.size() == 0) begin
        $error("unexpected output beat, crystal %0d", hit_crystal);
        errors++;
      end else begin
        exp_b = pending_hits.pop_front();
        if (entry_valid !== exp_b.valid) begin
          $error("entry_valid: expected %0d, got %0d", exp_b.valid, entry_valid);
          errors++;
        end
        if (hit_crystal !== exp_b.id) begin
          $error("hit_crystal: expected %0d, got %0d", exp_b.id, hit_crystal);
          errors++;
        end
        if (energy_sum !== exp_b.sum) begin
          $error("energy_sum: expected %0d, got %0d", exp_b.sum, energy_sum);
          errors++;
        end
        if (pos_x !== exp_b.x) begin
          $error("pos_x: expected %0d, got %0d", exp_b.x, pos_x);
          errors++;
        end
        if (pos_y !== exp_b.y) begin
          $error("pos_y: expected %0d, got %0d", exp_b.y, pos_y);
          errors++;
        end
        if (pos_z !== exp_b.z) begin
          $error("pos_z: expected %0d, got %0d", exp_b.z, pos_z);
          errors++;
        end
        if (overflow !== exp_b.ovf) begin
          $error("overflow: expected %0d, got %0d", exp_b.ovf, overflow);
          errors++;
        end
        if (last !== exp_b.last) begin
          $error("last: expected %0d, got %0d", exp_b.last, last);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic req, logic [cha_pkg::ID_W-1:0] id,
                           logic [cha_pkg::E_W-1:0] e);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    req_type = req;
    crystal_id = id;
    deposit_energy = e;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict(req, id, e);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_deposit(logic [cha_pkg::ID_W-1:0] id, logic [cha_pkg::E_W-1:0] e);
    send_item(REQ_DEPOSIT, id, e);
  endtask

  task automatic send_flush();
    send_item(REQ_FLUSH, cha_pkg::ID_W'($urandom), cha_pkg::E_W'($urandom));
  endtask

  // hold off until the list has drained and the block has settled
  task automatic wait_drained();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [cha_pkg::CIDX_W-1:0] idx, logic [cha_pkg::LEN_W-1:0] data);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == cha_pkg::REG_SIDE) side_reg = data[cha_pkg::SIDE_W-1:0];
    else if (idx == cha_pkg::REG_LEN) len_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    send_flush();                       // empty list right after reset
    send_deposit(12'd0, 24'd0);
    send_deposit(12'd63, 24'hFFFFFF);
    send_deposit(12'd0, 24'd5);
    send_deposit(12'd4095, 24'h555555); // far outside the array
    send_deposit(12'hAAA, 24'hAAAAAA);
    send_deposit(12'h555, 24'd1);
    send_deposit(12'd63, 24'd7);
    send_flush();
    send_flush();
  endtask

  task automatic test_config_extremes();
    logic [cha_pkg::SIDE_W-1:0] sides[6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd8};
    logic [cha_pkg::LEN_W-1:0] lens[6] = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd12345,
                                           cha_pkg::LEN_RST};
    for (int c = 0; c < 6; c++) begin
      write_reg(cha_pkg::REG_SIDE, {9'd0, sides[c]});
      write_reg(cha_pkg::REG_LEN, lens[c]);
      send_deposit(12'd0, 24'd1);
      send_deposit(12'd4095, 24'd2);
      send_flush();
    end
  endtask

  // fill the list; later deposits to unlisted crystals are dropped
  task automatic test_list_full();
    for (int k = 0; k < cha_pkg::MAX_HITS; k++) begin
      send_deposit(cha_pkg::ID_W'(k * 3), cha_pkg::E_W'($urandom));
    end
    send_deposit(12'd4000, 24'd1);      // dropped
    send_deposit(12'd3, 24'd100);       // still accumulates
    send_deposit(12'd4001, 24'd1);
  endtask

  // drive a listed crystal past the top of the sum while the list stays full
  task automatic test_saturation();
    calm = 1'b1;
    for (int k = 0; k < 257; k++) send_deposit(12'd9, 24'hFFFFFF);
    calm = 1'b0;
    send_deposit(12'd10, 24'd3);
    send_flush();
    send_flush();                       // flag cleared by the flush
  endtask

  task automatic test_random_events();
    int items;
    int len;
    int pool;
    int r;
    items = 0;
    while (items < 16) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(cha_pkg::REG_SIDE,
                  cha_pkg::LEN_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 16)));
        write_reg(cha_pkg::REG_LEN, cha_pkg::LEN_W'($urandom));
      end
      calm = ($urandom_range(0, 4) == 0);
      len = $urandom_range(0, 6);
      pool = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          send_deposit(cha_pkg::ID_W'($urandom_range(0, pool * 4)),
                       cha_pkg::E_W'($urandom_range(0, 4096)));
        end else begin
          send_deposit(cha_pkg::ID_W'($urandom), cha_pkg::E_W'($urandom));
        end
        items++;
      end
      send_flush();
      items++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_extremes();
    test_list_full();
    test_saturation();
    test_random_events();
    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d flushes and %0d output beats across side/length extremes,",
             flushes, beats_seen);
    $display("sum saturation, full list with dropped deposits and random events");
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("crystal_hit_accumulator test passed");
    end else begin
      $display("crystal_hit_accumulator test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("crystal_hit_accumulator test failed");
    $finish;
  end
endmodule
